### hdl/lcd4_pkg.sv
// shared types, constants and the microprogram table (init and byte transfer) of the lcd sequencer
package lcd4_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_INIT   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  // microprogram step kinds
  typedef enum logic [1:0] {
    K_WAIT = 2'd0,
    K_NIB  = 2'd1,
    K_HI   = 2'd2,
    K_LO   = 2'd3
  } kind_t;

  localparam int StepW = 5;
  localparam int WaitW = 14;

  localparam logic [WaitW-1:0] POWER_UP_WAIT_TICKS = 14'd15000;
  localparam logic [WaitW-1:0] SETTLE_TICKS        = 14'd50;
  localparam logic [WaitW-1:0] STROBE_TICKS        = 14'd1;

  localparam logic [StepW-1:0] STEP_IDLE  = 5'd0;
  localparam logic [StepW-1:0] INIT_START = 5'd1;
  localparam logic [StepW-1:0] BYTE_START = 5'd22;
  localparam logic [StepW-1:0] PROG_LEN   = 5'd25;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  // one input item
  typedef struct packed {
    op_t        op;
    logic       reg_select;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] column;
  } lcd_req_t;

  // one result item
  typedef struct packed {
    logic       rs_line;
    logic       enable_line;
    logic [3:0] data_lines;
    logic       busy_res;
    logic       rejected;
  } lcd_res_t;

  // one microprogram entry
  typedef struct packed {
    kind_t            kind;
    logic             last;
    logic [WaitW-1:0] val;
  } micro_op_t;

  // init program, then the generic byte transfer at BYTE_START
  function automatic micro_op_t prog_entry(input logic [StepW-1:0] step);
    micro_op_t e;
    e = '{kind: K_WAIT, last: 1'b1, val: '0};
    unique case (step)
      5'd1:  e = '{kind: K_WAIT, last: 1'b0, val: POWER_UP_WAIT_TICKS};
      5'd2:  e = '{kind: K_NIB,  last: 1'b0, val: 14'h3};
      5'd3:  e = '{kind: K_WAIT, last: 1'b0, val: 14'd5000};
      5'd4:  e = '{kind: K_NIB,  last: 1'b0, val: 14'h3};
      5'd5:  e = '{kind: K_WAIT, last: 1'b0, val: 14'd150};
      5'd6:  e = '{kind: K_NIB,  last: 1'b0, val: 14'h3};
      5'd7:  e = '{kind: K_WAIT, last: 1'b0, val: 14'd50};
      5'd8:  e = '{kind: K_NIB,  last: 1'b0, val: 14'h2};
      // function set 0x28
      5'd9:  e = '{kind: K_NIB,  last: 1'b0, val: 14'h2};
      5'd10: e = '{kind: K_NIB,  last: 1'b0, val: 14'h8};
      5'd11: e = '{kind: K_WAIT, last: 1'b0, val: 14'd50};
      // display on 0x0c
      5'd12: e = '{kind: K_NIB,  last: 1'b0, val: 14'h0};
      5'd13: e = '{kind: K_NIB,  last: 1'b0, val: 14'hC};
      5'd14: e = '{kind: K_WAIT, last: 1'b0, val: 14'd50};
      // clear 0x01 plus its long wait
      5'd15: e = '{kind: K_NIB,  last: 1'b0, val: 14'h0};
      5'd16: e = '{kind: K_NIB,  last: 1'b0, val: 14'h1};
      5'd17: e = '{kind: K_WAIT, last: 1'b0, val: 14'd50};
      5'd18: e = '{kind: K_WAIT, last: 1'b0, val: 14'd2000};
      // entry mode 0x06
      5'd19: e = '{kind: K_NIB,  last: 1'b0, val: 14'h0};
      5'd20: e = '{kind: K_NIB,  last: 1'b0, val: 14'h6};
      5'd21: e = '{kind: K_WAIT, last: 1'b1, val: 14'd50};
      // byte transfer
      5'd22: e = '{kind: K_HI,   last: 1'b0, val: '0};
      5'd23: e = '{kind: K_LO,   last: 1'b0, val: '0};
      5'd24: e = '{kind: K_WAIT, last: 1'b1, val: 14'd50};
      default: e = '{kind: K_WAIT, last: 1'b1, val: '0};
    endcase
    return e;
  endfunction

endpackage

### hdl/lcd4_in_stage.sv
// input register stage of the lcd sequencer
module lcd4_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcd4_pkg::lcd_req_t in_item,
  input  logic              take,
  output logic              held_valid,
  output lcd4_pkg::lcd_req_t held_item
);

  // stall only while the held item cannot move on
  assign in_stall = held_valid && !take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!held_valid || take) begin
      held_valid <= in_valid;
    end
  end

  // payload, loaded on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_item;
    end
  end

endmodule

### hdl/lcd4_sequencer.sv
// microprogram state and one-item step logic of the lcd sequencer
module lcd4_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  lcd4_pkg::lcd_req_t item,
  output lcd4_pkg::lcd_res_t res
);

  logic [lcd4_pkg::StepW-1:0] program_step, program_step_next;
  logic [lcd4_pkg::WaitW-1:0] wait_remaining, wait_remaining_next;
  logic [7:0]                 latched_byte, latched_byte_next;
  logic                       latched_rs, latched_rs_next;
  logic                       enable_level, enable_level_next;
  logic [3:0]                 nibble_out, nibble_out_next;

  logic                       running;
  logic                       do_enter;
  logic [lcd4_pkg::StepW-1:0] enter_target;
  lcd4_pkg::micro_op_t        cur_op;
  lcd4_pkg::micro_op_t        new_op;
  logic                       rejected;

  assign running = (program_step != lcd4_pkg::STEP_IDLE) &&
                   (program_step < lcd4_pkg::PROG_LEN);
  assign cur_op  = lcd4_pkg::prog_entry(program_step);
  assign new_op  = lcd4_pkg::prog_entry(enter_target);

  // tick handling, request latching, then entry into a new step
  always_comb begin
    program_step_next   = program_step;
    wait_remaining_next = wait_remaining;
    latched_byte_next   = latched_byte;
    latched_rs_next     = latched_rs;
    enable_level_next   = enable_level;
    nibble_out_next     = nibble_out;
    do_enter            = 1'b0;
    enter_target        = lcd4_pkg::STEP_IDLE;
    rejected            = 1'b0;

    if (item.op == lcd4_pkg::OP_TICK) begin
      if (!running) begin
        program_step_next = lcd4_pkg::STEP_IDLE;
      end else if (wait_remaining > lcd4_pkg::STROBE_TICKS) begin
        wait_remaining_next = wait_remaining - lcd4_pkg::STROBE_TICKS;
      end else if (enable_level) begin
        enable_level_next   = 1'b0;
        wait_remaining_next = lcd4_pkg::SETTLE_TICKS;
      end else if (cur_op.last) begin
        program_step_next   = lcd4_pkg::STEP_IDLE;
        wait_remaining_next = '0;
      end else begin
        do_enter     = 1'b1;
        enter_target = program_step + 5'd1;
      end
    end else if (program_step != lcd4_pkg::STEP_IDLE) begin
      rejected = 1'b1;
    end else begin
      do_enter = 1'b1;
      unique case (item.op)
        lcd4_pkg::OP_INIT: begin
          latched_rs_next = 1'b0;
          enter_target    = lcd4_pkg::INIT_START;
        end
        lcd4_pkg::OP_WRITE: begin
          latched_rs_next   = item.reg_select;
          latched_byte_next = item.byte_value;
          enter_target      = lcd4_pkg::BYTE_START;
        end
        default: begin
          // set cursor: row base plus column never exceeds seven bits
          latched_rs_next   = 1'b0;
          latched_byte_next = lcd4_pkg::CMD_SET_ADDR | {1'b0, item.row, item.column};
          enter_target      = lcd4_pkg::BYTE_START;
        end
      endcase
    end

    // step entry
    if (do_enter) begin
      if (enter_target == lcd4_pkg::STEP_IDLE || enter_target >= lcd4_pkg::PROG_LEN) begin
        program_step_next   = lcd4_pkg::STEP_IDLE;
        wait_remaining_next = '0;
        enable_level_next   = 1'b0;
      end else begin
        program_step_next = enter_target;
        unique case (new_op.kind)
          lcd4_pkg::K_NIB: begin
            nibble_out_next     = new_op.val[3:0];
            enable_level_next   = 1'b1;
            wait_remaining_next = lcd4_pkg::STROBE_TICKS;
          end
          lcd4_pkg::K_HI: begin
            nibble_out_next     = latched_byte_next[7:4];
            enable_level_next   = 1'b1;
            wait_remaining_next = lcd4_pkg::STROBE_TICKS;
          end
          lcd4_pkg::K_LO: begin
            nibble_out_next     = latched_byte_next[3:0];
            enable_level_next   = 1'b1;
            wait_remaining_next = lcd4_pkg::STROBE_TICKS;
          end
          default: begin
            enable_level_next   = 1'b0;
            wait_remaining_next = new_op.val;
          end
        endcase
      end
    end
  end

  // result of this item
  always_comb begin
    res.rs_line     = latched_rs_next;
    res.enable_line = enable_level_next;
    res.data_lines  = nibble_out_next;
    res.busy_res    = (program_step_next != lcd4_pkg::STEP_IDLE);
    res.rejected    = rejected;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      program_step   <= lcd4_pkg::STEP_IDLE;
      wait_remaining <= '0;
      latched_byte   <= '0;
      latched_rs     <= 1'b0;
      enable_level   <= 1'b0;
      nibble_out     <= '0;
    end else if (step_en) begin
      program_step   <= program_step_next;
      wait_remaining <= wait_remaining_next;
      latched_byte   <= latched_byte_next;
      latched_rs     <= latched_rs_next;
      enable_level   <= enable_level_next;
      nibble_out     <= nibble_out_next;
    end
  end

endmodule

### hdl/char_lcd_4bit_write_sequencer_core.sv
// top level of the 4-bit character lcd write sequencer
// path: each input passes the input register, then the result register, before its result is valid
// throughput: one item per cycle while out_stall is low; the step logic updates all sequencer state per item
// reset: synchronous rst empties both registers and returns the sequencer to idle,
// with all pin levels and latched values at zero
module char_lcd_4bit_write_sequencer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcd4_pkg::lcd_req_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lcd4_pkg::lcd_res_t out_item
);

  logic               held_valid;
  lcd4_pkg::lcd_req_t held_item;
  logic               take;
  lcd4_pkg::lcd_res_t step_res;

  // the held item moves on when the result register is free
  assign take = held_valid && (!out_valid || !out_stall);

  lcd4_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  lcd4_sequencer u_sequencer (
    .clk     (clk),
    .rst     (rst),
    .step_en (take),
    .item    (held_item),
    .res     (step_res)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= held_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= step_res;
    end
  end

endmodule
